// ----- hw/rtl/pidpc_pkg.sv -----
// pidpc_pkg: shared types, widths, register indexes and fixed-point helpers
// for the position PID controller. No dependencies.
package pidpc_pkg;

  localparam int FRAC_W     = 24;
  localparam int GAIN_W     = 32;
  localparam int LIM_W      = 15;
  localparam int POS_W      = 16;
  localparam int DIFF_W     = 17;
  localparam int PROD_W     = 50;
  localparam int SUM_W      = 51;
  localparam int ACC_W      = 52;
  localparam int INT_W      = 40;
  localparam int DRV_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int RES_FIFO_DEPTH = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KP_GAIN     = 3'd0;
  localparam cfg_idx_t REG_KI_GAIN     = 3'd1;
  localparam cfg_idx_t REG_KD_GAIN     = 3'd2;
  localparam cfg_idx_t REG_OUT_LIMIT   = 3'd3;
  localparam cfg_idx_t REG_P_ON_ERROR  = 3'd4;
  localparam cfg_idx_t REG_PID_ENABLED = 3'd5;

  localparam logic [GAIN_W-1:0] KP_RESET  = 32'd41943040;
  localparam logic [GAIN_W-1:0] KI_RESET  = 32'd3355;
  localparam logic [GAIN_W-1:0] KD_RESET  = 32'd1677721600;
  localparam logic [LIM_W-1:0]  LIM_RESET = 15'd255;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_OFF,
    KIND_RUN
  } kind_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]  lim;
    logic              p_on_err;
    logic              en;
  } cfg_t;

  // symmetric clamp of a Q.24 value to +/- lim * 2^24
  function automatic logic signed [INT_W-1:0] clamp_sym(
    input logic signed [ACC_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-LIM_W-FRAC_W){1'b0}}, lim, {FRAC_W{1'b0}}});
    lo = -hi;
    if (v > hi) begin
      return hi[INT_W-1:0];
    end else if (v < lo) begin
      return lo[INT_W-1:0];
    end
    return v[INT_W-1:0];
  endfunction

  // Q.24 to integer, truncated toward zero
  function automatic logic [DRV_W-1:0] trunc_drive(input logic signed [INT_W-1:0] o);
    logic signed [INT_W:0] t;
    logic signed [INT_W:0] bias;
    bias = o[INT_W-1] ? $signed({{(INT_W+1-FRAC_W){1'b0}}, {FRAC_W{1'b1}}}) : '0;
    t = $signed({o[INT_W-1], o}) + bias;
    return t[FRAC_W +: DRV_W];
  endfunction

endpackage

// ----- hw/rtl/pid_position_controller_top.sv -----
// pid_position_controller_top: position PID controller with anti-windup.
// Depends on pidpc_pkg, pidpc_datapath and pidpc_fifo.
//
// Usage:
//   Input channel in_valid/in_stall carries req_type, position and setpoint.
//   A compute item (req_type 0) yields one drive item on out_valid/out_stall;
//   an init item (req_type 1) clears the integral, loads the previous
//   position and yields nothing.
//   Configuration: cfg_we, cfg_index, cfg_wdata; write only while idle.
//   An item passes the input, product, sum, integral and result registers, then the queue, before out_valid.
//   Throughput: one item per cycle while in_stall is low; the integral update
//   (add plus clamp) is combinational logic closing on int_r, so consecutive items need no gap.
//   Results sit in a result queue of FIFO_DEPTH entries. Every accepted
//   compute item reserves a slot; in_stall rises only once all slots are
//   reserved, so a stalled receiver holds off new input after that many
//   pending results and nothing is lost.
//   Reset (rst_n low, synchronous) loads the register defaults, clears the
//   integral and previous position and empties the pipeline and queue.
module pid_position_controller_top #(
  parameter int FIFO_DEPTH = pidpc_pkg::RES_FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic signed [pidpc_pkg::POS_W-1:0]  in_position,
  input  logic signed [pidpc_pkg::POS_W-1:0]  in_setpoint,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pidpc_pkg::DRV_W-1:0]  out_drive,
  input  logic                                cfg_we,
  input  pidpc_pkg::cfg_idx_t                 cfg_index,
  input  logic [pidpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pidpc_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(FIFO_DEPTH);

  cfg_t             cfg_r, cfg_nxt;
  logic [CNT_W-1:0] credit_r, credit_nxt;
  logic             in_take, out_take, reserve;
  logic             res_valid;
  logic [DRV_W-1:0] res_drive, q_drive;

  assign in_stall  = (credit_r == SLOTS);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign reserve   = in_take && !in_req_type;
  assign out_drive = $signed(q_drive);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN:     cfg_nxt.kp       = cfg_wdata[GAIN_W-1:0];
        REG_KI_GAIN:     cfg_nxt.ki       = cfg_wdata[GAIN_W-1:0];
        REG_KD_GAIN:     cfg_nxt.kd       = cfg_wdata[GAIN_W-1:0];
        REG_OUT_LIMIT:   cfg_nxt.lim      = cfg_wdata[LIM_W-1:0];
        REG_P_ON_ERROR:  cfg_nxt.p_on_err = cfg_wdata[0];
        REG_PID_ENABLED: cfg_nxt.en       = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    credit_nxt = credit_r;
    if (reserve && !out_take) begin
      credit_nxt = credit_r + 1'b1;
    end else if (!reserve && out_take) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp       <= KP_RESET;
      cfg_r.ki       <= KI_RESET;
      cfg_r.kd       <= KD_RESET;
      cfg_r.lim      <= LIM_RESET;
      cfg_r.p_on_err <= 1'b1;
      cfg_r.en       <= 1'b0;
      credit_r       <= '0;
    end else begin
      cfg_r    <= cfg_nxt;
      credit_r <= credit_nxt;
    end
  end

  pidpc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_take     (in_take),
    .in_req_type (in_req_type),
    .in_position (in_position),
    .in_setpoint (in_setpoint),
    .res_valid   (res_valid),
    .res_drive   (res_drive)
  );

  pidpc_fifo #(
    .WIDTH (DRV_W),
    .DEPTH (FIFO_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_drive),
    .pop       (out_take),
    .not_empty (out_valid),
    .rd_data   (q_drive)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= SLOTS)
    else $error("slot reservation count out of range");

  a_credit_covers_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (credit_r != '0))
    else $error("result present without a reserved slot");

  a_no_pop_without_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (credit_r == '0) |-> !out_valid && !res_valid)
    else $error("result without reservation");

endmodule

// ----- hw/rtl/pidpc_fifo.sv -----
// pidpc_fifo: small flop-based result queue for the PID controller.
// Depends on nothing; parameters set width and depth.
module pidpc_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && (cnt_r == FULL) && !do_pop))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("result queue count out of range");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> not_empty)
    else $error("pushed item not visible");

endmodule

// ----- hw/rtl/pidpc_datapath.sv -----
// pidpc_datapath: input register, product stage, term sums, integral update
// and drive clamp. Uses pidpc_pkg.
module pidpc_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pidpc_pkg::cfg_t                 cfg,
  input  logic                            in_take,
  input  logic                            in_req_type,
  input  logic signed [pidpc_pkg::POS_W-1:0] in_position,
  input  logic signed [pidpc_pkg::POS_W-1:0] in_setpoint,
  output logic                            res_valid,
  output logic [pidpc_pkg::DRV_W-1:0]     res_drive
);
  import pidpc_pkg::*;

  // stage 1: captured item
  logic                     v1_r;
  kind_t                    kind1_r;
  logic signed [POS_W-1:0]  pos1_r, sp1_r, prv1_r;
  logic signed [POS_W-1:0]  prev_pos_r;

  // stage 2: products
  logic                     v2_r;
  kind_t                    kind2_r;
  logic signed [PROD_W-1:0] p_kp_r, p_ki_r, p_kd_r;

  // stage 3: integral term and output term
  logic                     v3_r;
  kind_t                    kind3_r;
  logic signed [SUM_W-1:0]  a3_r, b3_r;

  // stage 4: integral
  logic                     v4_r;
  logic                     run4_r;
  logic signed [INT_W-1:0]  int_r, int_nxt;
  logic signed [INT_W-1:0]  s4_r;
  logic signed [SUM_W-1:0]  b4_r;

  // stage 5: result
  logic                     v5_r;
  logic [DRV_W-1:0]         drive5_r;

  logic signed [DIFF_W-1:0] err, dpos, kp_x;
  logic signed [PROD_W-1:0] p_kp_nxt, p_ki_nxt, p_kd_nxt;
  logic signed [SUM_W-1:0]  a_nxt, b_nxt;
  logic signed [ACC_W-1:0]  int_sum, out_sum;
  logic signed [INT_W-1:0]  o_clamped;
  kind_t                    kind_in;

  assign kind_in = in_req_type ? KIND_INIT : (cfg.en ? KIND_RUN : KIND_OFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      prev_pos_r <= '0;
    end else begin
      v1_r <= in_take;
      if (in_take) begin
        prev_pos_r <= in_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind1_r <= kind_in;
      pos1_r  <= in_position;
      sp1_r   <= in_setpoint;
      prv1_r  <= prev_pos_r;
    end
  end

  always_comb begin
    err      = $signed({sp1_r[POS_W-1], sp1_r}) - $signed({pos1_r[POS_W-1], pos1_r});
    dpos     = $signed({pos1_r[POS_W-1], pos1_r}) - $signed({prv1_r[POS_W-1], prv1_r});
    kp_x     = cfg.p_on_err ? err : dpos;
    p_kp_nxt = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.kp}) * PROD_W'(kp_x);
    p_ki_nxt = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.ki}) * PROD_W'(err);
    p_kd_nxt = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.kd}) * PROD_W'(dpos);
  end

  always_comb begin
    a_nxt = $signed({p_ki_r[PROD_W-1], p_ki_r});
    b_nxt = -$signed({p_kd_r[PROD_W-1], p_kd_r});
    if (cfg.p_on_err) begin
      b_nxt = b_nxt + $signed({p_kp_r[PROD_W-1], p_kp_r});
    end else begin
      a_nxt = a_nxt - $signed({p_kp_r[PROD_W-1], p_kp_r});
    end
  end

  always_comb begin
    int_sum = ACC_W'(int_r) + ACC_W'(a3_r);
    int_nxt = int_r;
    if (v3_r) begin
      if (kind3_r == KIND_RUN) begin
        int_nxt = clamp_sym(int_sum, cfg.lim);
      end else begin
        int_nxt = '0;
      end
    end
  end

  always_comb begin
    out_sum   = ACC_W'(s4_r) + ACC_W'(b4_r);
    o_clamped = clamp_sym(out_sum, cfg.lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      int_r <= '0;
    end else begin
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r && (kind3_r != KIND_INIT);
      v5_r  <= v4_r;
      int_r <= int_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind2_r  <= kind1_r;
    p_kp_r   <= p_kp_nxt;
    p_ki_r   <= p_ki_nxt;
    p_kd_r   <= p_kd_nxt;
    kind3_r  <= kind2_r;
    a3_r     <= a_nxt;
    b3_r     <= b_nxt;
    run4_r   <= (kind3_r == KIND_RUN);
    s4_r     <= int_nxt;
    b4_r     <= b3_r;
    drive5_r <= run4_r ? trunc_drive(o_clamped) : '0;
  end

  assign res_valid = v5_r;
  assign res_drive = drive5_r;

  a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ($signed(drive5_r) <= $signed({1'b0, cfg.lim}))
          && ($signed(drive5_r) >= -$signed({1'b0, cfg.lim})))
    else $error("drive outside limit");

  a_init_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (kind3_r == KIND_INIT) |=> !v4_r)
    else $error("init item produced a result");

  a_clear_integral: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (kind3_r != KIND_RUN) |=> (int_r == '0))
    else $error("integral not cleared");

endmodule

// ----- tb/pid_position_controller_top_test.sv -----
`timescale 1ns / 100ps
// pid_position_controller_top_test: self-checking bench for the position PID controller.
// Predicts every drive item with its own Q.24 model and checks it against the block.
// Depends on pidpc_pkg and pid_position_controller_top.
module pid_position_controller_top_test;
  import pidpc_pkg::*;

  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_INIT = 1'b1;
  localparam cfg_idx_t REG_UNUSED_6 = 3'd6;
  localparam cfg_idx_t REG_UNUSED_7 = 3'd7;
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;
  localparam longint Q24_ONE = 64'sd16777216;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int BURST_ITEMS = 140;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = REQ_STEP;
  logic signed [POS_W-1:0] in_position = '0;
  logic signed [POS_W-1:0] in_setpoint = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DRV_W-1:0] out_drive;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = REG_KP_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cfg_t ctl;
  longint integ_q24;
  logic signed [POS_W-1:0] last_pos;
  logic signed [DRV_W-1:0] drive_q[$];
  logic signed [DRV_W-1:0] exp_drive;

  int send_gap_pct = 0;
  int rcv_stall_pct = 0;
  int unsigned n_steps = 0;
  int unsigned n_inits = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;

  pid_position_controller_top i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_q24(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic predict_drive(logic req, logic signed [POS_W-1:0] pos,
                               logic signed [POS_W-1:0] sp);
    longint kp, ki, kd, err, dpos, lim, s, o;
    if (req == REQ_INIT) begin
      integ_q24 = 0;
      last_pos = pos;
      n_inits++;
      return;
    end
    n_steps++;
    if (!ctl.en) begin
      integ_q24 = 0;
      last_pos = pos;
      drive_q.push_back('0);
      return;
    end
    kp = longint'(ctl.kp);
    ki = longint'(ctl.ki);
    kd = longint'(ctl.kd);
    lim = longint'(ctl.lim);
    lim = lim <<< FRAC_W;
    err = longint'(sp) - longint'(pos);
    dpos = longint'(pos) - longint'(last_pos);
    s = integ_q24 + ki * err;
    if (!ctl.p_on_err) s -= kp * dpos;
    s = clamp_q24(s, lim);
    integ_q24 = s;
    o = s - kd * dpos;
    if (ctl.p_on_err) o += kp * err;
    o = clamp_q24(o, lim);
    last_pos = pos;
    drive_q.push_back(DRV_W'(o / Q24_ONE));
  endtask

  // leaves cfg_we high; the caller lowers it after its last write
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    n_writes++;
    case (idx)
      REG_KP_GAIN:     ctl.kp = data;
      REG_KI_GAIN:     ctl.ki = data;
      REG_KD_GAIN:     ctl.kd = data;
      REG_OUT_LIMIT:   ctl.lim = data[LIM_W-1:0];
      REG_P_ON_ERROR:  ctl.p_on_err = data[0];
      REG_PID_ENABLED: ctl.en = data[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                               logic [GAIN_W-1:0] kd, logic [LIM_W-1:0] lim,
                               logic p_on_err, logic en);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_OUT_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_P_ON_ERROR, CFG_DATA_W'(p_on_err));
    write_reg(REG_PID_ENABLED, CFG_DATA_W'(en));
    cfg_we <= 1'b0;
  endtask

  // valid stays high after acceptance so back-to-back items need one assignment
  task automatic send_item(logic req, logic signed [POS_W-1:0] pos,
                           logic signed [POS_W-1:0] sp);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_setpoint <= sp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_drive(req, pos, sp);
  endtask

  // init items leave nothing queued, so allow the pipeline to empty as well
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain(int unsigned span);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom_range(span);
    endcase
  endfunction

  task automatic random_settings();
    logic [LIM_W-1:0] lim;
    case ($urandom_range(7))
      0: lim = '0;
      1: lim = '1;
      default: lim = LIM_W'($urandom_range(1, 2000));
    endcase
    load_settings(pick_gain(32'd8 << 24), pick_gain(32'd1 << 20), pick_gain(32'd16 << 24),
                  lim, 1'($urandom_range(1)), $urandom_range(9) != 0);
  endtask

  // mostly a servo tracking a target that moves now and then; some noise and inits
  task automatic random_burst(int n);
    int track, target, roll;
    track = int'($urandom_range(65535)) - 32768;
    target = int'($urandom_range(65535)) - 32768;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_quiet();
      roll = $urandom_range(99);
      if (roll < 4) begin
        track = int'($urandom_range(65535)) - 32768;
        send_item(REQ_INIT, POS_W'(track), POS_W'(target));
      end else if (roll < 24) begin
        send_item(REQ_STEP, POS_W'($urandom), POS_W'($urandom));
      end else begin
        if ($urandom_range(9) == 0) target = int'($urandom_range(65535)) - 32768;
        track += (target - track) / 8 + int'($urandom_range(40)) - 20;
        if (track > 32767) track = 32767;
        if (track < -32768) track = -32768;
        send_item(REQ_STEP, POS_W'(track), POS_W'(target));
      end
    end
  endtask

  task automatic test_disabled_default();
    send_item(REQ_STEP, POS_MAX, POS_MIN);
    send_item(REQ_STEP, POS_MIN, POS_MAX);
    send_item(REQ_INIT, 16'sd100, 16'sd0);
    send_item(REQ_STEP, 16'sd0, 16'sd0);
  endtask

  task automatic test_register_writes();
    wait_quiet();
    write_reg(REG_KP_GAIN, 32'h0100_0000);
    write_reg(REG_KI_GAIN, 32'h0000_0000);
    write_reg(REG_KD_GAIN, 32'h0000_0000);
    write_reg(REG_OUT_LIMIT, 32'hFFFF_0064);
    write_reg(REG_P_ON_ERROR, 32'hFFFF_FFFE);
    write_reg(REG_PID_ENABLED, 32'h8000_0003);
    write_reg(REG_UNUSED_6, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED_7, 32'h0000_0000);
    cfg_we <= 1'b0;
    send_item(REQ_INIT, 16'sd0, 16'sd0);
    send_item(REQ_STEP, 16'sd10, 16'sd60);
    send_item(REQ_STEP, 16'sd300, 16'sd0);
  endtask

  task automatic test_extremes();
    wait_quiet();
    load_settings('1, '1, '1, '1, 1'b1, 1'b1);
    send_item(REQ_STEP, POS_MIN, POS_MAX);
    send_item(REQ_STEP, POS_MAX, POS_MIN);
    wait_quiet();
    load_settings('0, '0, '0, '1, 1'b1, 1'b1);
    send_item(REQ_STEP, POS_MAX, POS_MIN);
  endtask

  task automatic test_zero_limit();
    wait_quiet();
    load_settings(KP_RESET, KI_RESET, KD_RESET, '0, 1'b1, 1'b1);
    send_item(REQ_STEP, 16'sd0, 16'sd1000);
    send_item(REQ_STEP, -16'sd500, 16'sd500);
    send_item(REQ_STEP, POS_MAX, POS_MIN);
  endtask

  // half-unit results must round toward zero on both sides
  task automatic test_truncation();
    wait_quiet();
    load_settings(32'h0080_0000, '0, '0, 15'd100, 1'b1, 1'b1);
    send_item(REQ_STEP, 16'sd3, 16'sd0);
    send_item(REQ_STEP, 16'sd0, 16'sd3);
    send_item(REQ_STEP, 16'sd0, 16'sd1);
    send_item(REQ_STEP, 16'sd1, 16'sd0);
  endtask

  task automatic test_bumpless_init();
    wait_quiet();
    load_settings(KP_RESET, 32'h0040_0000, 32'h0100_0000, LIM_RESET, 1'b1, 1'b1);
    send_item(REQ_STEP, 16'sd0, 16'sd50);
    send_item(REQ_STEP, 16'sd20, 16'sd50);
    send_item(REQ_INIT, 16'sd200, 16'sd0);
    send_item(REQ_STEP, 16'sd200, 16'sd200);
  endtask

  task automatic test_random_traffic();
    int gaps[3] = '{8, 72, 0};
    int stalls[3] = '{72, 8, 0};
    for (int m = 0; m < 3; m++) begin
      send_gap_pct = gaps[m];
      rcv_stall_pct = stalls[m];
      for (int k = 0; k < 3; k++) begin
        wait_quiet();
        random_settings();
        random_burst(BURST_ITEMS);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: drive item %0d arrived with none expected", $time, out_drive);
      end else begin
        exp_drive = drive_q.pop_front();
        n_checked++;
        if (out_drive !== exp_drive) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: drive expected %0d, got %0d", $time, exp_drive, out_drive);
        end
      end
    end
    out_stall <= $urandom_range(99) < rcv_stall_pct;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pid_position_controller_top verification failed");
    $finish;
  end

  initial begin
    ctl = '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET, lim: LIM_RESET,
            p_on_err: 1'b1, en: 1'b0};
    integ_q24 = 0;
    last_pos = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_default();
    test_register_writes();
    test_extremes();
    test_zero_limit();
    test_truncation();
    test_bumpless_init();
    test_random_traffic();
    wait_quiet();
    $display("Covered %0d compute and %0d init items, %0d drive items checked, %0d writes",
             n_steps, n_inits, n_checked, n_writes);
    $display("Limits from zero to full scale, both P modes, enable off and on, three idle mixes");
    if (n_errors == 0 && drive_q.size() == 0) begin
      $display("pid_position_controller_top verification clean");
    end else begin
      $display("pid_position_controller_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pidpc_pkg.sv
hw/rtl/pidpc_fifo.sv
hw/rtl/pidpc_datapath.sv
hw/rtl/pid_position_controller_top.sv
tb/pid_position_controller_top_test.sv
